/* rtl/core/b64d_pkg.sv */
package b64d_pkg;

   // character codes with a meaning of their own
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PAD   = 8'h3d;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7a;

   localparam logic [5:0] SEXTET_LO_BASE  = 6'd26;
   localparam logic [5:0] SEXTET_DIG_BASE = 6'd52;
   localparam logic [5:0] SEXTET_PLUS     = 6'd62;
   localparam logic [5:0] SEXTET_SLASH    = 6'd63;

   // queue depths must be powers of two, pointers wrap by overflow
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam int RSPQ_DEPTH = 2;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_SEXTET,
      KIND_SKIP,
      KIND_NUL,
      KIND_PAD
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [5:0] sextet;
   } cmd_type;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] count;
      logic       eos;
   } rsp_type;

   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [7:0] diff;
      begin
         diff = 8'd0;
         sextet_of = 6'd0;
         if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            diff = c - CHAR_UP_A;
            sextet_of = diff[5:0];
         end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            diff = c - CHAR_LO_A;
            sextet_of = SEXTET_LO_BASE + diff[5:0];
         end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff = c - CHAR_ZERO;
            sextet_of = SEXTET_DIG_BASE + diff[5:0];
         end else if (c == CHAR_PLUS) begin
            sextet_of = SEXTET_PLUS;
         end else if (c == CHAR_SLASH) begin
            sextet_of = SEXTET_SLASH;
         end
      end
   endfunction

   function automatic kind_type kind_of(input logic [7:0] c);
      begin
         if (c == CHAR_NUL) begin
            kind_of = KIND_NUL;
         end else if (c == CHAR_CR || c == CHAR_LF) begin
            kind_of = KIND_SKIP;
         end else if (c == CHAR_PAD) begin
            kind_of = KIND_PAD;
         end else begin
            kind_of = KIND_SEXTET;
         end
      end
   endfunction

endpackage

/* rtl/core/b64d_front.sv */
module b64d_front (
   input  logic                 req_push,
   input  logic [7:0]           req_char_code,
   output logic                 req_full,
   input  logic                 cmdq_full,
   output logic                 cmdq_push,
   output b64d_pkg::cmd_type    cmdq_data
);

   b64d_pkg::cmd_type cmd;

   always_comb begin
      cmd.kind   = b64d_pkg::kind_of(req_char_code);
      cmd.sextet = b64d_pkg::sextet_of(req_char_code);
   end

   // line breaks are accepted and dropped here
   assign req_full  = cmdq_full;
   assign cmdq_push = req_push && !cmdq_full && (cmd.kind != b64d_pkg::KIND_SKIP);
   assign cmdq_data = cmd;

endmodule

/* rtl/core/b64d_cmdq.sv */
module b64d_cmdq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64d_pkg::cmd_type    push_data,
   output logic                 full,
   input  logic                 pop,
   output b64d_pkg::cmd_type    pop_data,
   output logic                 empty
);

   b64d_pkg::cmd_type                   mem_ff [b64d_pkg::CMDQ_DEPTH];
   logic [b64d_pkg::CMDQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [b64d_pkg::CMDQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [b64d_pkg::CMDQ_CNT_W-1:0]     count_ff, count_in;
   logic                                do_push, do_pop;

   assign full     = (count_ff == b64d_pkg::CMDQ_CNT_W'(b64d_pkg::CMDQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/b64d_back.sv */
module b64d_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmdq_empty,
   input  b64d_pkg::cmd_type    cmdq_data,
   output logic                 cmdq_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output b64d_pkg::rsp_type    rsp_data
);

   logic [1:0]                          sextet_count_ff, sextet_count_in;
   logic [17:0]                         bit_accumulator_ff, bit_accumulator_in;
   logic [23:0]                         full_group;
   logic                                has_rsp;
   b64d_pkg::rsp_type                   rsp_new;

   b64d_pkg::rsp_type                   mem_ff [b64d_pkg::RSPQ_DEPTH];
   logic [b64d_pkg::RSPQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [b64d_pkg::RSPQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [b64d_pkg::RSPQ_CNT_W-1:0]     count_ff, count_in;
   logic                                rspq_full, do_push, do_pop;

   assign full_group = {bit_accumulator_ff, cmdq_data.sextet};

   always_comb begin
      has_rsp            = 1'b1;
      rsp_new            = '0;
      rsp_new.eos        = 1'b1;
      sextet_count_in    = '0;
      bit_accumulator_in = '0;
      case (cmdq_data.kind)
         b64d_pkg::KIND_SEXTET: begin
            if (sextet_count_ff == 2'd3) begin
               rsp_new.byte0 = full_group[23:16];
               rsp_new.byte1 = full_group[15:8];
               rsp_new.byte2 = full_group[7:0];
               rsp_new.count = 2'd3;
               rsp_new.eos   = 1'b0;
            end else begin
               has_rsp            = 1'b0;
               bit_accumulator_in = full_group[17:0];
               sextet_count_in    = sextet_count_ff + 2'd1;
            end
         end
         b64d_pkg::KIND_PAD: begin
            // flush what the partial group holds
            if (sextet_count_ff == 2'd3) begin
               rsp_new.byte0 = bit_accumulator_ff[17:10];
               rsp_new.byte1 = bit_accumulator_ff[9:2];
               rsp_new.count = 2'd2;
            end else if (sextet_count_ff == 2'd2) begin
               rsp_new.byte0 = bit_accumulator_ff[11:4];
               rsp_new.count = 2'd1;
            end
         end
         b64d_pkg::KIND_NUL: begin
            has_rsp = 1'b1;
         end
         default: begin
            has_rsp            = 1'b0;
            sextet_count_in    = sextet_count_ff;
            bit_accumulator_in = bit_accumulator_ff;
         end
      endcase
   end

   // stall on a full result queue only when this command makes a result
   assign rspq_full = (count_ff == b64d_pkg::RSPQ_CNT_W'(b64d_pkg::RSPQ_DEPTH));
   assign cmdq_pop  = !cmdq_empty && !(has_rsp && rspq_full);
   assign do_push   = cmdq_pop && has_rsp;
   assign rsp_empty = (count_ff == '0);
   assign do_pop    = rsp_pop && !rsp_empty;
   assign rsp_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sextet_count_ff    <= '0;
         bit_accumulator_ff <= '0;
         wr_ptr_ff          <= '0;
         rd_ptr_ff          <= '0;
         count_ff           <= '0;
      end else begin
         if (cmdq_pop) begin
            sextet_count_ff    <= sextet_count_in;
            bit_accumulator_ff <= bit_accumulator_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= rsp_new;
      end
   end

endmodule

/* rtl/core/base64_stream_decoder_core.sv */
// channel    ports                                   handshake
// request    req_char_code                           req_push / req_full
// response   rsp_out_byte0..2, rsp_byte_count,       rsp_pop / rsp_empty
//            rsp_end_of_stream
//
// one character is taken every cycle while req_full is low. the fourth sextet
// of a group, a pad and a nul each make a response: the accepting edge writes
// the command queue, then the decode step writes the response queue.
// both queues hold two. reset clears the sextet count, the accumulator and
// both queues. a stalled rsp_pop backs up the response queue, then the command
// queue, and only then raises req_full.
module base64_stream_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_char_code,
   output logic       req_full,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_byte0,
   output logic [7:0] rsp_out_byte1,
   output logic [7:0] rsp_out_byte2,
   output logic [1:0] rsp_byte_count,
   output logic       rsp_end_of_stream
);

   b64d_pkg::cmd_type cmdq_push_data;
   b64d_pkg::cmd_type cmdq_pop_data;
   b64d_pkg::rsp_type rsp_data;
   logic              cmdq_push, cmdq_full, cmdq_pop, cmdq_empty;

   b64d_front u_front (
      .req_push      (req_push),
      .req_char_code (req_char_code),
      .req_full      (req_full),
      .cmdq_full     (cmdq_full),
      .cmdq_push     (cmdq_push),
      .cmdq_data     (cmdq_push_data)
   );

   b64d_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmdq_push),
      .push_data (cmdq_push_data),
      .full      (cmdq_full),
      .pop       (cmdq_pop),
      .pop_data  (cmdq_pop_data),
      .empty     (cmdq_empty)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmdq_empty (cmdq_empty),
      .cmdq_data  (cmdq_pop_data),
      .cmdq_pop   (cmdq_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data)
   );

   assign rsp_out_byte0     = rsp_data.byte0;
   assign rsp_out_byte1     = rsp_data.byte1;
   assign rsp_out_byte2     = rsp_data.byte2;
   assign rsp_byte_count    = rsp_data.count;
   assign rsp_end_of_stream = rsp_data.eos;

endmodule
